### rtl/bgtr_pkg.sv
// Shared types and constants for the bitmap glyph text renderer.
// No dependencies; used by bitmap_glyph_text_renderer_unit.
`default_nettype none

package bgtr_pkg;

  // Font geometry defaults.
  localparam int GLYPH_COUNT      = 96;
  localparam int MAX_GLYPH_WIDTH  = 8;
  localparam int MAX_GLYPH_HEIGHT = 16;

  // At most this many rows leave for one character.
  localparam int ROWS_OUT_MAX = 16;

  // Printable character range mapped onto the font.
  localparam logic [7:0] CODE_FIRST = 8'd32;
  localparam logic [7:0] CODE_LAST  = 8'd127;

  // Register reset values.
  localparam logic [3:0]  RST_GLYPH_WIDTH  = 4'd8;
  localparam logic [4:0]  RST_GLYPH_HEIGHT = 5'd16;
  localparam logic [12:0] RST_SCREEN_WIDTH = 13'd640;
  localparam logic [12:0] RST_SCREEN_HEIGHT = 13'd480;
  localparam logic [14:0] RST_SCREEN_PITCH = 15'd640;
  localparam logic [2:0]  RST_BPP          = 3'd1;
  localparam logic [31:0] RST_FG_COLOR     = 32'd255;
  localparam logic [7:0]  RST_BG_INDEX     = 8'd0;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_CHAR  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_GLYPH_WIDTH   = 3'd0,
    REG_GLYPH_HEIGHT  = 3'd1,
    REG_SCREEN_WIDTH  = 3'd2,
    REG_SCREEN_HEIGHT = 3'd3,
    REG_SCREEN_PITCH  = 3'd4,
    REG_BPP           = 3'd5,
    REG_FG_COLOR      = 3'd6,
    REG_BG_INDEX      = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BASE,
    ST_ROW
  } state_t;

endpackage

`default_nettype wire

### rtl/bitmap_glyph_text_renderer_unit.sv
// Bitmap glyph text renderer: font memory, pen state and row emitter.
// Depends on bgtr_pkg.
// Load and start items are accepted in idle; in_ready stays high for them.
// A rendered character passes the product registers, then the row offset
// with row 0 read, then the output register; after that it emits one row
// per cycle unless out_ready stalls, paced by read port and output register.
// Other characters stay idle. Reset clears control state and registers only.
`default_nettype none

module bitmap_glyph_text_renderer_unit #(
  parameter int GLYPH_COUNT      = bgtr_pkg::GLYPH_COUNT,
  parameter int MAX_GLYPH_WIDTH  = bgtr_pkg::MAX_GLYPH_WIDTH,
  parameter int MAX_GLYPH_HEIGHT = bgtr_pkg::MAX_GLYPH_HEIGHT
) (
  input  wire logic        clk,
  input  wire logic        rst,

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,

  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  op,
  input  wire logic [11:0] pen_x,
  input  wire logic [11:0] pen_y,
  input  wire logic        center,
  input  wire logic [11:0] text_length,
  input  wire logic [7:0]  char_code,
  input  wire logic [6:0]  glyph_index,
  input  wire logic [3:0]  glyph_row,
  input  wire logic [63:0] glyph_pixels,

  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [25:0]      byte_offset,
  output logic [7:0]       pixel_mask,
  output logic [31:0]      color,
  output logic             last_row
);

  localparam int FontDepth = GLYPH_COUNT * MAX_GLYPH_HEIGHT;
  localparam int AW        = (FontDepth > 1) ? $clog2(FontDepth) : 1;
  localparam int RowsMax   = (MAX_GLYPH_HEIGHT < bgtr_pkg::ROWS_OUT_MAX) ?
                             MAX_GLYPH_HEIGHT : bgtr_pkg::ROWS_OUT_MAX;
  localparam int RW        = (RowsMax > 1) ? $clog2(RowsMax) : 1;

  // Configuration registers
  logic [3:0]  glyph_width;
  logic [4:0]  glyph_height;
  logic [12:0] screen_width;
  logic [12:0] screen_height;
  logic [14:0] screen_pitch;
  logic [2:0]  bytes_per_pixel;
  logic [31:0] fg_color;
  logic [7:0]  background_index;

  // Pen and string state
  logic        font_loaded;
  logic [12:0] cursor_x;
  logic [11:0] line_y;
  logic        string_dropped;
  logic        string_stopped;

  // Per-character work registers
  bgtr_pkg::state_t state, state_next;
  logic [AW-1:0] glyph_base;
  logic [25:0]   line_prod;
  logic [15:0]   col_prod;
  logic [25:0]   row_offset;
  logic [RW-1:0] row;
  logic [31:0]  char_color;

  // Font memory
  logic [MAX_GLYPH_WIDTH-1:0] font_mem [FontDepth];
  logic [MAX_GLYPH_WIDTH-1:0] mem_q;
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [MAX_GLYPH_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]              mem_raddr;
  logic [RW-1:0]              rd_row;

  logic [3:0]  eff_w;
  logic [4:0]  eff_h;
  logic [2:0]  eff_bpp;
  logic        accept;
  bgtr_pkg::op_t in_op;
  logic        load_row;
  logic        row_last;
  logic        char_go;
  logic        char_stop;
  logic [6:0]  code_glyph;
  logic [6:0]  glyph_sel;
  logic [15:0] center_prod;
  logic [14:0] center_half;
  logic [11:0] start_x;
  logic        load_ok;
  logic [31:0] color_sel;
  logic [MAX_GLYPH_WIDTH-1:0] width_mask;

  assign cfg_ready = 1'b1;
  assign in_op     = bgtr_pkg::op_t'(op);
  assign accept    = in_valid && in_ready;

  // Clamped views of the registers
  always_comb begin
    eff_w = glyph_width;
    if (glyph_width == 4'd0) eff_w = 4'd1;
    if (glyph_width > 4'(MAX_GLYPH_WIDTH)) eff_w = 4'(MAX_GLYPH_WIDTH);
    eff_h = glyph_height;
    if (glyph_height == 5'd0) eff_h = 5'd1;
    if (glyph_height > 5'(RowsMax)) eff_h = 5'(RowsMax);
    eff_bpp = bytes_per_pixel;
    if (bytes_per_pixel == 3'd0) eff_bpp = 3'd1;
    if (bytes_per_pixel > 3'd4) eff_bpp = 3'd4;
  end

  always_comb begin
    unique case (eff_bpp)
      3'd1:    color_sel = {24'd0, fg_color[7:0]};
      3'd2:    color_sel = {16'd0, fg_color[15:0]};
      3'd3:    color_sel = {8'd0, fg_color[23:0]};
      default: color_sel = fg_color;
    endcase
  end

  always_comb begin
    for (int j = 0; j < MAX_GLYPH_WIDTH; j++) begin
      width_mask[j] = (4'(j) < eff_w);
      mem_wdata[j]  = (glyph_pixels[8*j +: 8] != background_index);
    end
  end

  // Load items
  assign load_ok   = (32'(glyph_index) < GLYPH_COUNT) &&
                     (32'(glyph_row) < MAX_GLYPH_HEIGHT);
  assign mem_we    = accept && (in_op == bgtr_pkg::OP_LOAD) && load_ok;
  assign mem_waddr = AW'(32'(glyph_index) * MAX_GLYPH_HEIGHT + 32'(glyph_row));

  // Start items: pen start, optionally centered
  assign center_prod = 16'(text_length) * 16'(eff_w);
  assign center_half = center_prod[15:1];
  assign start_x     = !center ? pen_x :
                       (center_half > 15'(pen_x)) ? 12'd0 : pen_x - center_half[11:0];

  // Character items
  assign char_stop = ({1'b0, cursor_x} + 14'(eff_w)) > {1'b0, screen_width};
  assign char_go   = accept && (in_op == bgtr_pkg::OP_CHAR) && font_loaded &&
                     !string_dropped && !string_stopped && !char_stop;

  always_comb begin
    code_glyph = 7'd0;
    if (char_code >= bgtr_pkg::CODE_FIRST && char_code <= bgtr_pkg::CODE_LAST) begin
      code_glyph = 7'(char_code - bgtr_pkg::CODE_FIRST);
    end
    glyph_sel = (32'(code_glyph) >= GLYPH_COUNT) ? 7'd0 : code_glyph;
  end

  // FSM next state
  always_comb begin
    state_next = state;
    unique case (state)
      bgtr_pkg::ST_IDLE: if (char_go) state_next = bgtr_pkg::ST_BASE;
      bgtr_pkg::ST_BASE: state_next = bgtr_pkg::ST_ROW;
      bgtr_pkg::ST_ROW:  if (load_row && row_last) state_next = bgtr_pkg::ST_IDLE;
      default:           state_next = bgtr_pkg::ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_ready = 1'b0;
    load_row = 1'b0;
    rd_row   = row;
    unique case (state)
      bgtr_pkg::ST_IDLE: in_ready = 1'b1;
      bgtr_pkg::ST_BASE: rd_row = '0;
      bgtr_pkg::ST_ROW: begin
        load_row = !out_valid || out_ready;
        if (load_row) rd_row = row + 1'b1;
      end
      default: in_ready = 1'b0;
    endcase
  end

  assign row_last  = (5'(row) == eff_h - 5'd1);
  assign mem_raddr = glyph_base + AW'(rd_row);

  always_ff @(posedge clk) begin
    if (mem_we) font_mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    mem_q <= font_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_width      <= bgtr_pkg::RST_GLYPH_WIDTH;
      glyph_height     <= bgtr_pkg::RST_GLYPH_HEIGHT;
      screen_width     <= bgtr_pkg::RST_SCREEN_WIDTH;
      screen_height    <= bgtr_pkg::RST_SCREEN_HEIGHT;
      screen_pitch     <= bgtr_pkg::RST_SCREEN_PITCH;
      bytes_per_pixel  <= bgtr_pkg::RST_BPP;
      fg_color         <= bgtr_pkg::RST_FG_COLOR;
      background_index <= bgtr_pkg::RST_BG_INDEX;
    end else if (cfg_valid && cfg_ready) begin
      unique case (bgtr_pkg::reg_idx_t'(cfg_index))
        bgtr_pkg::REG_GLYPH_WIDTH:   glyph_width      <= cfg_data[3:0];
        bgtr_pkg::REG_GLYPH_HEIGHT:  glyph_height     <= cfg_data[4:0];
        bgtr_pkg::REG_SCREEN_WIDTH:  screen_width     <= cfg_data[12:0];
        bgtr_pkg::REG_SCREEN_HEIGHT: screen_height    <= cfg_data[12:0];
        bgtr_pkg::REG_SCREEN_PITCH:  screen_pitch     <= cfg_data[14:0];
        bgtr_pkg::REG_BPP:           bytes_per_pixel  <= cfg_data[2:0];
        bgtr_pkg::REG_FG_COLOR:      fg_color         <= cfg_data;
        bgtr_pkg::REG_BG_INDEX:      background_index <= cfg_data[7:0];
        default:                     fg_color         <= fg_color;
      endcase
    end
  end

  // Pen state and control
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= bgtr_pkg::ST_IDLE;
      font_loaded    <= 1'b0;
      cursor_x       <= '0;
      line_y         <= '0;
      string_dropped <= 1'b1;
      string_stopped <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (mem_we) font_loaded <= 1'b1;
      if (accept && in_op == bgtr_pkg::OP_START) begin
        cursor_x       <= {1'b0, start_x};
        line_y         <= pen_y;
        string_stopped <= 1'b0;
        string_dropped <= !font_loaded ||
                          ((13'(pen_y) + 13'(eff_h)) > screen_height);
      end
      if (accept && in_op == bgtr_pkg::OP_CHAR && font_loaded &&
          !string_dropped && !string_stopped && char_stop) begin
        string_stopped <= 1'b1;
      end
      if (char_go) cursor_x <= cursor_x + 13'(eff_w);
      if (load_row) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (char_go) begin
      glyph_base <= AW'(32'(glyph_sel) * MAX_GLYPH_HEIGHT);
      line_prod  <= 26'(27'(line_y) * 27'(screen_pitch));
      col_prod   <= 16'(cursor_x) * 16'(eff_bpp);
      char_color <= color_sel;
    end
    if (state == bgtr_pkg::ST_BASE) begin
      row_offset <= line_prod + 26'(col_prod);
      row        <= '0;
    end else if (load_row) begin
      row_offset <= row_offset + 26'(screen_pitch);
      row        <= row + 1'b1;
    end
    if (load_row) begin
      byte_offset <= row_offset;
      pixel_mask  <= 8'(mem_q & width_mask);
      color       <= char_color;
      last_row    <= row_last;
    end
  end

  // Checks
  a_base_to_row: assert property (@(posedge clk) disable iff (rst)
    state == bgtr_pkg::ST_BASE |=> state == bgtr_pkg::ST_ROW)
    else $error("setup cycle not followed by row emission");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    load_row && row_last |=> state == bgtr_pkg::ST_IDLE && out_valid && last_row)
    else $error("last row did not end the character");

  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> state == bgtr_pkg::ST_IDLE)
    else $error("font write while a character is in flight");

  a_reset_drop: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> string_dropped && !font_loaded && !out_valid)
    else $error("string state not cleared by reset");

endmodule

`default_nettype wire
